// ----- rtl/core/rssi_median_ema_publisher_macros.svh -----
// Assertion macros shared by the checker of the RSSI median/EMA publisher.
// Each macro expects signals named clk and rst_n in the scope of use.
`ifndef RSSI_MEDIAN_EMA_PUBLISHER_MACROS_SVH
`define RSSI_MEDIAN_EMA_PUBLISHER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RMEP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RMEP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/rmep_pkg.sv -----
// Shared types and constants of the RSSI median/EMA publisher.
// Used by the stream interface users, the core modules and the checker.
`default_nettype none

package rmep_pkg;

    localparam int RSSI_W      = 8;
    localparam int EMA_W       = 16;
    localparam int TIME_W      = 32;
    localparam int THRESH_W    = 16;
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 32;

    // Request codes carried in req_type.
    typedef enum logic [1:0] {
        REQ_SAMPLE = 2'd0,
        REQ_CHECK  = 2'd1,
        REQ_CLEAR  = 2'd2,
        REQ_IDLE   = 2'd3
    } req_code_t;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_PUBLISH_INTERVAL = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] CFG_EMA_THRESHOLD    = CFG_INDEX_W'(1);

    localparam logic [TIME_W-1:0]   INTERVAL_RESET  = 32'd1000;
    localparam logic [THRESH_W-1:0] THRESHOLD_RESET = 16'd512;

    // Divide by five: floor(x * 52429 / 2^18) equals floor(x / 5) for x below 2^18.
    localparam logic [15:0] DIV5_RECIP = 16'd52429;
    localparam int          DIV5_SHIFT = 18;

    typedef struct packed {
        logic [1:0]               req_type;
        logic signed [RSSI_W-1:0] rssi;
        logic [TIME_W-1:0]        now_ms;
    } in_beat_t;

    typedef struct packed {
        logic signed [RSSI_W-1:0] median_rssi;
        logic signed [EMA_W-1:0]  ema_out;
        logic                     window_full;
        logic                     publish_now;
        logic [TIME_W-1:0]        last_seen_ms;
    } out_beat_t;

    typedef struct packed {
        logic [CFG_INDEX_W-1:0] index;
        logic [CFG_DATA_W-1:0]  data;
    } cfg_beat_t;

endpackage

`default_nettype wire

// ----- rtl/core/rmep_stream_if.sv -----
// Valid/ready stream channel with a typed payload.
// Instantiated once per channel with a beat type from rmep_pkg.
`default_nettype none

interface rmep_stream_if #(parameter type payload_t = logic);

    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);

endinterface

`default_nettype wire

// ----- rtl/core/rssi_median_ema_publisher.sv -----
// Top level of the RSSI median/EMA publisher: handshakes, state and publish decision.
// Depends on rmep_pkg, rmep_stream_if, rmep_median and rmep_ema_step.
//
//   Channel  Role    Beat type    Content
//   in_ch    sink    in_beat_t    request code, RSSI sample, timestamp
//   out_ch   source  out_beat_t   median, EMA, full flag, publish flag, last seen time
//   cfg_ch   sink    cfg_beat_t   register index and write data, always ready
//
// One item is taken per clock cycle while out_ch does not stall. An accepted beat lands in
// the input register and is processed there by one pass of logic (median network, EMA
// divide by five, publish compare); its result is loaded into the result register when
// the held beat moves on, and a stall on out_ch delays that.
// Reset is asynchronous and active low; it restores the default configuration and an
// empty window at once, with no clearing pass. A stall on out_ch holds the result
// and the pending input beat; in_ch stays ready while the input register can move on.
`default_nettype none

module rssi_median_ema_publisher #(
    parameter int WINDOW_SIZE = 5
) (
    input  logic          clk,
    input  logic          rst_n,
    rmep_stream_if.sink   in_ch,
    rmep_stream_if.source out_ch,
    rmep_stream_if.sink   cfg_ch
);
    import rmep_pkg::*;

    localparam int SLOT_W  = $clog2(WINDOW_SIZE);
    localparam int COUNT_W = $clog2(WINDOW_SIZE + 1);

    localparam logic [SLOT_W-1:0]  LAST_SLOT  = SLOT_W'(WINDOW_SIZE - 1);
    localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(WINDOW_SIZE);

    // Configuration registers.
    logic [TIME_W-1:0]   interval_reg;
    logic [THRESH_W-1:0] threshold_reg;
    cfg_beat_t           cfg_beat;

    // Input and result registers of the single processing stage.
    in_beat_t  in_beat;
    logic      in_vld_reg;
    in_beat_t  in_beat_reg;
    logic      out_vld_reg;
    out_beat_t out_beat_reg;
    out_beat_t out_beat_next;
    logic      advance;

    // Window and filter state. The ring itself is payload: only the first
    // fill_reg entries are ever read, so it needs no reset.
    logic signed [RSSI_W-1:0] ring_reg [WINDOW_SIZE];
    logic signed [RSSI_W-1:0] ring_new [WINDOW_SIZE];
    logic [SLOT_W-1:0]        slot_reg;
    logic [SLOT_W-1:0]        slot_next;
    logic [COUNT_W-1:0]       fill_reg;
    logic [COUNT_W-1:0]       fill_next;
    logic [COUNT_W-1:0]       fill_inc;
    logic                     seeded_reg;
    logic                     seeded_next;
    logic signed [EMA_W-1:0]  ema_reg;
    logic signed [EMA_W-1:0]  ema_next;
    logic signed [EMA_W-1:0]  ema_step;
    logic signed [RSSI_W-1:0] med_reg;
    logic signed [RSSI_W-1:0] med_next;
    logic signed [RSSI_W-1:0] med_new;
    logic signed [EMA_W-1:0]  pub_ema_reg;
    logic signed [EMA_W-1:0]  pub_ema_next;
    logic [TIME_W-1:0]        pub_time_reg;
    logic [TIME_W-1:0]        pub_time_next;
    logic [TIME_W-1:0]        seen_reg;
    logic [TIME_W-1:0]        seen_next;

    // Request decode and publish decision.
    req_code_t          req;
    logic               is_sample;
    logic               window_full;
    logic [TIME_W-1:0]  elapsed;
    logic signed [16:0] ema_diff;
    logic [16:0]        ema_change;
    logic               fire;

    // ------------------------------------------------------------------
    // Configuration port: writes are taken on every valid beat.
    // ------------------------------------------------------------------
    assign cfg_ch.ready = 1'b1;
    assign cfg_beat     = cfg_ch.payload;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interval_reg  <= INTERVAL_RESET;
            threshold_reg <= THRESHOLD_RESET;
        end
        else if (cfg_ch.valid)
        begin
            case (cfg_beat.index)
                CFG_PUBLISH_INTERVAL: interval_reg  <= cfg_beat.data;
                CFG_EMA_THRESHOLD:    threshold_reg <= cfg_beat.data[THRESH_W-1:0];
                default:              ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Handshake. The held beat moves on when the result register is empty
    // or being emptied; a new beat may enter in the same cycle.
    // ------------------------------------------------------------------
    assign in_beat        = in_ch.payload;
    assign advance        = in_vld_reg && (!out_vld_reg || out_ch.ready);
    assign in_ch.ready    = !in_vld_reg || advance;
    assign out_ch.valid   = out_vld_reg;
    assign out_ch.payload = out_beat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (in_ch.ready)
            begin
                in_vld_reg <= in_ch.valid;
            end
            if (advance)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.ready && in_ch.valid)
        begin
            in_beat_reg <= in_beat;
        end
        if (advance)
        begin
            out_beat_reg <= out_beat_next;
        end
    end

    // ------------------------------------------------------------------
    // Sample path: the new sample goes into the write slot, the window is
    // ranked with it in place and its median drives the EMA update.
    // ------------------------------------------------------------------
    assign req       = req_code_t'(in_beat_reg.req_type);
    assign is_sample = (req == REQ_SAMPLE);

    always_comb
    begin
        for (int i = 0; i < WINDOW_SIZE; i++)
        begin
            ring_new[i] = (slot_reg == SLOT_W'(i)) ? in_beat_reg.rssi : ring_reg[i];
        end
    end

    assign fill_inc = (fill_reg == FULL_COUNT) ? fill_reg : fill_reg + COUNT_W'(1);

    rmep_median #(
        .WINDOW_SIZE (WINDOW_SIZE)
    ) u_median (
        .samples (ring_new),
        .count   (fill_inc),
        .median  (med_new)
    );

    rmep_ema_step u_ema_step (
        .ema_cur (ema_reg),
        .median  (med_new),
        .seeded  (seeded_reg),
        .ema_new (ema_step)
    );

    // ------------------------------------------------------------------
    // Publish check. Never having published makes the interval count as
    // elapsed; the time difference wraps modulo 2^32.
    // ------------------------------------------------------------------
    assign window_full = (fill_reg == FULL_COUNT);
    assign elapsed     = (pub_time_reg == '0) ? interval_reg : in_beat_reg.now_ms - pub_time_reg;
    assign ema_diff    = 17'(ema_reg) - 17'(pub_ema_reg);
    assign ema_change  = ema_diff[16] ? 17'(-ema_diff) : 17'(ema_diff);
    assign fire        = (req == REQ_CHECK) && window_full &&
                         (elapsed >= interval_reg || ema_change >= {1'b0, threshold_reg});

    // ------------------------------------------------------------------
    // Next state and result of the held request.
    // ------------------------------------------------------------------
    always_comb
    begin
        slot_next     = slot_reg;
        fill_next     = fill_reg;
        seeded_next   = seeded_reg;
        ema_next      = ema_reg;
        med_next      = med_reg;
        pub_ema_next  = pub_ema_reg;
        pub_time_next = pub_time_reg;
        seen_next     = seen_reg;
        case (req)
            REQ_SAMPLE:
            begin
                slot_next   = (slot_reg == LAST_SLOT) ? '0 : slot_reg + SLOT_W'(1);
                fill_next   = fill_inc;
                seeded_next = 1'b1;
                ema_next    = ema_step;
                med_next    = med_new;
                seen_next   = in_beat_reg.now_ms;
            end
            REQ_CHECK:
            begin
                if (fire)
                begin
                    pub_ema_next  = ema_reg;
                    pub_time_next = in_beat_reg.now_ms;
                end
            end
            REQ_CLEAR:
            begin
                // The publish latches and the last-seen time survive a clear.
                slot_next   = '0;
                fill_next   = '0;
                seeded_next = 1'b0;
                ema_next    = '0;
                med_next    = '0;
            end
            REQ_IDLE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        out_beat_next.median_rssi  = med_next;
        out_beat_next.ema_out      = ema_next;
        out_beat_next.window_full  = (fill_next == FULL_COUNT);
        out_beat_next.publish_now  = fire;
        out_beat_next.last_seen_ms = seen_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg     <= '0;
            fill_reg     <= '0;
            seeded_reg   <= 1'b0;
            ema_reg      <= '0;
            med_reg      <= '0;
            pub_ema_reg  <= '0;
            pub_time_reg <= '0;
            seen_reg     <= '0;
        end
        else if (advance)
        begin
            slot_reg     <= slot_next;
            fill_reg     <= fill_next;
            seeded_reg   <= seeded_next;
            ema_reg      <= ema_next;
            med_reg      <= med_next;
            pub_ema_reg  <= pub_ema_next;
            pub_time_reg <= pub_time_next;
            seen_reg     <= seen_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && is_sample)
        begin
            ring_reg[slot_reg] <= in_beat_reg.rssi;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/rmep_median.sv -----
// Rank-select median over the filled entries of the sample window.
// Depends on rmep_pkg for the sample width.
`default_nettype none

module rmep_median #(
    parameter int WINDOW_SIZE = 5
) (
    input  logic signed [rmep_pkg::RSSI_W-1:0]      samples [WINDOW_SIZE],
    input  logic [$clog2(WINDOW_SIZE+1)-1:0]        count,
    output logic signed [rmep_pkg::RSSI_W-1:0]      median
);
    import rmep_pkg::*;

    localparam int COUNT_W = $clog2(WINDOW_SIZE + 1);
    localparam int RANK_W  = $clog2(WINDOW_SIZE);

    logic [RANK_W-1:0] rank [WINDOW_SIZE];
    logic [RANK_W-1:0] half;

    // Each filled entry counts the filled entries that sort before it; equal
    // values are ordered by position so the ranks form a permutation.
    always_comb
    begin
        for (int i = 0; i < WINDOW_SIZE; i++)
        begin
            rank[i] = '0;
            for (int j = 0; j < WINDOW_SIZE; j++)
            begin
                if (j != i && COUNT_W'(j) < count &&
                    (samples[j] < samples[i] || (samples[j] == samples[i] && j < i)))
                begin
                    rank[i] = rank[i] + RANK_W'(1);
                end
            end
        end
    end

    assign half = RANK_W'(count >> 1);

    always_comb
    begin
        median = '0;
        for (int i = 0; i < WINDOW_SIZE; i++)
        begin
            if (COUNT_W'(i) < count && rank[i] == half)
            begin
                median = samples[i];
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/rmep_ema_step.sv -----
// One EMA update: seed from the median, or (4*ema + 256*median)/5 rounded.
// Depends on rmep_pkg for widths and the divide-by-five reciprocal.
`default_nettype none

module rmep_ema_step (
    input  logic signed [rmep_pkg::EMA_W-1:0]  ema_cur,
    input  logic signed [rmep_pkg::RSSI_W-1:0] median,
    input  logic                               seeded,
    output logic signed [rmep_pkg::EMA_W-1:0]  ema_new
);
    import rmep_pkg::*;

    logic signed [18:0] sum;
    logic               neg;
    logic [18:0]        mag;
    logic [18:0]        biased;
    logic [34:0]        prod;
    logic [16:0]        quot;
    logic [16:0]        rounded;

    // 4*ema + 256*median always fits in 19 signed bits.
    assign sum = $signed({ema_cur[EMA_W-1], ema_cur, 2'b00})
               + $signed({{3{median[RSSI_W-1]}}, median, 8'b0});

    // Round half away from zero on the magnitude; five is odd so no ties occur.
    assign neg     = sum[18];
    assign mag     = neg ? 19'(-sum) : 19'(sum);
    assign biased  = mag + 19'd2;
    assign prod    = 35'(biased) * 35'(DIV5_RECIP);
    assign quot    = prod[DIV5_SHIFT +: 17];
    assign rounded = neg ? 17'(-quot) : quot;

    assign ema_new = seeded ? rounded[EMA_W-1:0] : {median, 8'b0};

endmodule

`default_nettype wire

// ----- rtl/core/rmep_checker.sv -----
// Port-level checks of the RSSI median/EMA publisher, bound to its top level.
// Depends on rmep_pkg and the assertion macros header.
`default_nettype none
`include "rssi_median_ema_publisher_macros.svh"

module rmep_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [$bits(rmep_pkg::out_beat_t)-1:0] out_bits
);
    import rmep_pkg::*;

    out_beat_t out_beat;

    assign out_beat = out_beat_t'(out_bits);

    // A stalled result stays offered and unchanged.
    `RMEP_ASSERT_NEXT(a_out_held, out_valid && !out_ready, out_valid, "result dropped while stalled")
    `RMEP_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_bits), "result changed while stalled")

    // A publish only ever fires on a full window.
    `RMEP_ASSERT_NOW(a_fire_full, out_valid && out_beat.publish_now, out_beat.window_full, "publish with window not full")

    // A fresh result follows an accepted beat through the input register and the result register.
    `RMEP_ASSERT_NOW(a_latency, $rose(out_valid), $past(in_valid && in_ready, 2), "result without a matching input beat")

endmodule

bind rssi_median_ema_publisher rmep_checker u_rmep_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_bits  (out_ch.payload)
);

`default_nettype wire

// ----- test/rssi_median_ema_checker.sv -----
`timescale 1ns / 1ps
// Checker for the RSSI median/EMA publisher: watches the request, result and register
// channels, predicts every result beat and compares it field by field.
// Depends on rmep_pkg for the beat types, request codes and register indexes.

module rssi_median_ema_checker
    import rmep_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      in_ready,
    input  in_beat_t  in_beat,
    input  logic      out_valid,
    input  logic      out_ready,
    input  out_beat_t out_beat,
    input  logic      cfg_valid,
    input  logic      cfg_ready,
    input  cfg_beat_t cfg_beat,
    output int        mismatches,
    output int        outstanding
);

    localparam int WINDOW = 5;

    // Shadow copy of the block's configuration and state.
    logic [TIME_W-1:0]        interval_ms;
    logic [THRESH_W-1:0]      threshold_q8;
    logic signed [RSSI_W-1:0] ring [WINDOW];
    logic [2:0]               slot;
    logic [2:0]               fill;
    logic                     seeded;
    logic signed [EMA_W-1:0]  ema;
    logic signed [EMA_W-1:0]  pub_ema;
    logic [TIME_W-1:0]        pub_time;
    logic [TIME_W-1:0]        seen_time;

    out_beat_t expected_results [$];
    out_beat_t predicted;
    out_beat_t oldest;
    int        fail_tally = 0;

    assign mismatches = fail_tally;

    task automatic empty_window();
        for (int i = 0; i < WINDOW; i++)
        begin
            ring[i] = '0;
        end
        slot   = '0;
        fill   = '0;
        seeded = 1'b0;
        ema    = '0;
    endtask

    // Median of the filled entries: the element at fill/2 in ascending order.
    function automatic logic signed [RSSI_W-1:0] window_median();
        logic signed [RSSI_W-1:0] sorted [WINDOW];
        logic signed [RSSI_W-1:0] v;
        int n;
        int i;
        int j;
        n = fill;
        if (n == 0)
        begin
            return '0;
        end
        for (i = 0; i < n; i++)
        begin
            v = ring[i];
            j = i;
            while (j > 0 && sorted[j-1] > v)
            begin
                sorted[j] = sorted[j-1];
                j--;
            end
            sorted[j] = v;
        end
        return sorted[n/2];
    endfunction

    // EMA step (4*ema + 256*median)/5, rounded to nearest and symmetric about zero.
    function automatic logic signed [EMA_W-1:0] blend_ema(logic signed [EMA_W-1:0] prev,
                                                          logic signed [RSSI_W-1:0] med);
        int sum;
        int rounded;
        sum = 4 * int'(prev) + 256 * int'(med);
        if (sum >= 0)
        begin
            rounded = (sum + 2) / 5;
        end
        else
        begin
            rounded = -((-sum + 2) / 5);
        end
        return EMA_W'(rounded);
    endfunction

    task automatic predict_status(input in_beat_t req, output out_beat_t res);
        logic signed [RSSI_W-1:0] med;
        logic [TIME_W-1:0]        elapsed;
        logic                     fire;
        int                       diff;
        int                       mag;
        fire = 1'b0;
        case (req.req_type)
            REQ_SAMPLE:
            begin
                ring[slot] = req.rssi;
                slot = (slot == WINDOW - 1) ? 3'd0 : slot + 3'd1;
                if (fill < WINDOW)
                begin
                    fill = fill + 3'd1;
                end
                med = window_median();
                if (!seeded)
                begin
                    ema    = EMA_W'(int'(med) * 256);
                    seeded = 1'b1;
                end
                else
                begin
                    ema = blend_ema(ema, med);
                end
                seen_time = req.now_ms;
            end
            REQ_CHECK:
            begin
                if (fill >= WINDOW)
                begin
                    // A latched time of zero reads as never published.
                    elapsed = (pub_time == '0) ? interval_ms : req.now_ms - pub_time;
                    diff    = int'(ema) - int'(pub_ema);
                    mag     = (diff < 0) ? -diff : diff;
                    if (elapsed >= interval_ms || mag >= int'(threshold_q8))
                    begin
                        fire     = 1'b1;
                        pub_time = req.now_ms;
                        pub_ema  = ema;
                    end
                end
            end
            REQ_CLEAR:
            begin
                empty_window();
            end
            default:
            begin
            end
        endcase
        res.median_rssi  = window_median();
        res.ema_out      = ema;
        res.window_full  = (fill >= WINDOW);
        res.publish_now  = fire;
        res.last_seen_ms = seen_time;
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            interval_ms  = INTERVAL_RESET;
            threshold_q8 = THRESHOLD_RESET;
            empty_window();
            pub_ema   = '0;
            pub_time  = '0;
            seen_time = '0;
            expected_results.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_beat.index == CFG_PUBLISH_INTERVAL)
                begin
                    interval_ms = cfg_beat.data;
                end
                else if (cfg_beat.index == CFG_EMA_THRESHOLD)
                begin
                    threshold_q8 = cfg_beat.data[THRESH_W-1:0];
                end
            end
            if (in_valid && in_ready)
            begin
                predict_status(in_beat, predicted);
                expected_results.push_back(predicted);
            end
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result beat arrived with no expected result pending");
                    fail_tally++;
                end
                else
                begin
                    oldest = expected_results.pop_front();
                    if (out_beat.median_rssi !== oldest.median_rssi)
                    begin
                        $error("median_rssi: expected %0d, actual %0d",
                               oldest.median_rssi, out_beat.median_rssi);
                        fail_tally++;
                    end
                    if (out_beat.ema_out !== oldest.ema_out)
                    begin
                        $error("ema_out: expected %0d, actual %0d",
                               oldest.ema_out, out_beat.ema_out);
                        fail_tally++;
                    end
                    if (out_beat.window_full !== oldest.window_full)
                    begin
                        $error("window_full: expected %0b, actual %0b",
                               oldest.window_full, out_beat.window_full);
                        fail_tally++;
                    end
                    if (out_beat.publish_now !== oldest.publish_now)
                    begin
                        $error("publish_now: expected %0b, actual %0b",
                               oldest.publish_now, out_beat.publish_now);
                        fail_tally++;
                    end
                    if (out_beat.last_seen_ms !== oldest.last_seen_ms)
                    begin
                        $error("last_seen_ms: expected %0d, actual %0d",
                               oldest.last_seen_ms, out_beat.last_seen_ms);
                        fail_tally++;
                    end
                end
            end
        end
        outstanding = expected_results.size();
    end

endmodule

// ----- test/tb_rssi_median_ema_publisher.sv -----
`timescale 1ns / 1ps
// Top of the RSSI median/EMA publisher testbench: clock, reset, request stimulus,
// register writes, receiver back-pressure, watchdog and the final verdict.
// Depends on rmep_pkg, rmep_stream_if, the block itself and rssi_median_ema_checker.

module tb_rssi_median_ema_publisher;
    import rmep_pkg::*;

    // Settling time allowed after the last expected result before a register write or the
    // verdict, so that nothing is still in flight.
    localparam int SETTLE_CYCLES = 6;

    // Longest run of cycles with no beat on any channel. A correct run stays well below it
    // even with 72 percent idling on one side, so this only trips when the block has
    // stopped.
    localparam int STALL_LIMIT = 2000;

    logic clk = 1'b0;
    logic rst_n;

    rmep_stream_if #(.payload_t(in_beat_t))  in_ch ();
    rmep_stream_if #(.payload_t(out_beat_t)) out_ch ();
    rmep_stream_if #(.payload_t(cfg_beat_t)) cfg_ch ();

    int mismatches;
    int outstanding;

    // Percentages of cycles in which the sender holds back and the receiver stalls.
    int send_idle_pct;
    int recv_idle_pct;

    // Running timestamp and RSSI level that the random requests drift around.
    logic [TIME_W-1:0]        stream_time;
    logic signed [RSSI_W-1:0] rssi_level;

    int stall_cycles = 0;

    rssi_median_ema_publisher u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg_ch (cfg_ch)
    );

    rssi_median_ema_checker u_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_ch.valid),
        .in_ready    (in_ch.ready),
        .in_beat     (in_ch.payload),
        .out_valid   (out_ch.valid),
        .out_ready   (out_ch.ready),
        .out_beat    (out_ch.payload),
        .cfg_valid   (cfg_ch.valid),
        .cfg_ready   (cfg_ch.ready),
        .cfg_beat    (cfg_ch.payload),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Receiver: ready is redrawn at every falling edge, exactly once per step.
    initial
    begin
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Watchdog: any beat on any channel restarts the count.
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
        begin
            stall_cycles = 0;
        end
        else
        begin
            stall_cycles++;
        end
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // All driving tasks start and end at a falling edge at which nothing has been
    // assigned yet, so valid is never lowered and raised within one step: it stays
    // high from one beat into the next unless the sender decides to idle.
    task automatic send_item(input req_code_t code, input logic signed [RSSI_W-1:0] rssi,
                             input logic [TIME_W-1:0] now);
        in_beat_t beat;
        beat.req_type = code;
        beat.rssi     = rssi;
        beat.now_ms   = now;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.payload <= beat;
        do
        begin
            @(posedge clk);
        end
        while (!in_ch.ready);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_beat_t beat;
        beat.index = index;
        beat.data  = data;
        cfg_ch.valid   <= 1'b1;
        cfg_ch.payload <= beat;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ch.ready);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
        @(negedge clk);
    endtask

    // Stop sending, wait for every expected result, then let the pipeline settle.
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (outstanding != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // One random request. Most are samples and publish checks on a slowly moving
    // clock so that the window fills and the publish logic is exercised; clears
    // break the sequences now and then, and unused request codes act as noise.
    task automatic send_random_item(output logic counted);
        int                       pick;
        req_code_t                code;
        logic signed [RSSI_W-1:0] rssi;
        pick = $urandom_range(0, 99);
        if (pick < 55)
        begin
            code = REQ_SAMPLE;
        end
        else if (pick < 88)
        begin
            code = REQ_CHECK;
        end
        else if (pick < 93)
        begin
            code = REQ_CLEAR;
        end
        else
        begin
            code = REQ_IDLE;
        end

        pick = $urandom_range(0, 99);
        if (pick < 85)
        begin
            stream_time = stream_time + TIME_W'($urandom_range(0, 700));
        end
        else if (pick < 95)
        begin
            stream_time = $urandom;
        end
        else
        begin
            stream_time = '0;
        end

        // A drifting level gives small EMA moves near the threshold; full-range
        // samples give large ones and cover every bit of the field.
        if ($urandom_range(0, 99) < 5)
        begin
            rssi_level = RSSI_W'($urandom_range(0, 255));
        end
        if ($urandom_range(0, 99) < 65)
        begin
            rssi = RSSI_W'($urandom_range(0, 255));
        end
        else
        begin
            rssi = rssi_level + RSSI_W'($urandom_range(0, 8)) - RSSI_W'(4);
        end

        send_item(code, rssi, stream_time);
        counted = (code != REQ_IDLE);
    endtask

    // A configuration setting followed by a run of random requests under it.
    task automatic run_segment(input logic [TIME_W-1:0] interval,
                               input logic [THRESH_W-1:0] threshold, input int count);
        int   done;
        logic counted;
        done = 0;
        drain();
        write_reg(CFG_PUBLISH_INTERVAL, interval);
        write_reg(CFG_EMA_THRESHOLD, CFG_DATA_W'(threshold));
        while (done < count)
        begin
            send_random_item(counted);
            if (counted)
            begin
                done++;
            end
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        in_ch.valid    = 1'b0;
        in_ch.payload  = '0;
        cfg_ch.valid   = 1'b0;
        cfg_ch.payload = '0;
        send_idle_pct  = 27;
        recv_idle_pct  = 72;
        stream_time    = '0;
        rssi_level     = -8'sd60;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part, under the reset configuration (1000 ms, 512).
        // A check on an empty window must not fire, and the unused code only
        // reports status.
        send_item(REQ_CHECK, 8'sd0, 32'd10);
        send_item(REQ_IDLE, -8'sd1, 32'hFFFF_FFFF);
        // Fill with the extremes of the sample range; a check on a partial window
        // stays quiet.
        send_item(REQ_SAMPLE, 8'sd127, 32'd0);
        send_item(REQ_SAMPLE, -8'sd128, 32'd1);
        send_item(REQ_SAMPLE, 8'sd0, 32'd2);
        send_item(REQ_CHECK, 8'sd0, 32'd3);
        send_item(REQ_SAMPLE, 8'sd127, 32'd4);
        send_item(REQ_SAMPLE, -8'sd1, 32'd5);
        // First publish happens at time zero, which still reads as never
        // published, so the next check fires again.
        send_item(REQ_CHECK, 8'sd0, 32'd0);
        send_item(REQ_CHECK, 8'sd0, 32'd5);
        send_item(REQ_CHECK, 8'sd0, 32'd2000);
        // Too early and no EMA movement: no publish.
        send_item(REQ_CHECK, 8'sd0, 32'd2500);
        // Pull the EMA down hard so the threshold forces a publish.
        send_item(REQ_SAMPLE, -8'sd128, 32'd2510);
        send_item(REQ_SAMPLE, -8'sd128, 32'd2520);
        send_item(REQ_SAMPLE, -8'sd128, 32'd2530);
        send_item(REQ_CHECK, 8'sd0, 32'd2600);
        // Time going backwards wraps to a huge elapsed value.
        send_item(REQ_CHECK, 8'sd0, 32'd1);
        send_item(REQ_SAMPLE, 8'sd127, 32'hFFFF_FFFF);
        // Clear keeps the last-seen time and the publish latches.
        send_item(REQ_CLEAR, 8'sd55, 32'd77);
        send_item(REQ_CHECK, 8'sd0, 32'd9000);
        // A negative first median seeds the EMA below zero.
        send_item(REQ_SAMPLE, -8'sd128, 32'd9001);
        send_item(REQ_SAMPLE, -8'sd100, 32'd9002);
        stream_time = 32'd9002;

        // Sender idles lightly, receiver stalls heavily. Zero interval means every
        // full-window check fires on time; the other segment has the zero threshold.
        run_segment(32'd0, 16'hFFFF, 100);
        run_segment(32'hFFFF_FFFF, 16'd0, 100);

        // The other way round: both limits at their maximum, then mid-range values.
        send_idle_pct = 72;
        recv_idle_pct = 27;
        run_segment(32'hFFFF_FFFF, 16'hFFFF, 100);
        run_segment(TIME_W'($urandom_range(1, 1500)), THRESH_W'($urandom_range(0, 1024)),
                    100);

        // No idling on either side.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_segment(INTERVAL_RESET, THRESHOLD_RESET, 100);
        run_segment(TIME_W'($urandom_range(1, 3000)), THRESH_W'($urandom_range(1, 600)),
                    100);

        drain();
        if (mismatches == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
